FILE: rtl/bgd_pkg.sv
// package for the button gesture detector
// event codes, register indexes, configuration and event bundle types
// no dependencies
package bgd_pkg;

   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_CLICK   = 3'd2,
      EV_DOUBLE  = 3'd3,
      EV_LONG    = 3'd4,
      EV_REPEAT  = 3'd5
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_DEBOUNCE        = 3'd0,
      REG_LONG_PRESS      = 3'd1,
      REG_DOUBLE_CLICK    = 3'd2,
      REG_REPEAT_ENABLE   = 3'd3,
      REG_REPEAT_DELAY    = 3'd4,
      REG_REPEAT_INTERVAL = 3'd5
   } csr_index_type;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam int unsigned MAX_EVENTS     = 3;

   localparam logic [15:0] DEBOUNCE_RESET        = 16'd5;
   localparam logic [15:0] LONG_PRESS_RESET      = 16'd800;
   localparam logic [15:0] DOUBLE_CLICK_RESET    = 16'd0;
   localparam logic        REPEAT_ENABLE_RESET   = 1'b0;
   localparam logic [15:0] REPEAT_DELAY_RESET    = 16'd500;
   localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd100;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] double_click_ms;
      logic        repeat_enable;
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_interval_ms;
   } bgd_cfg_type;

   // events caused by one sample, first in slot 0
   typedef struct packed {
      event_kind_type [MAX_EVENTS-1:0] kinds;
      logic [1:0]                      count;
      logic [31:0]                     stamp;
   } bgd_bundle_type;

endpackage

FILE: rtl/bgd_fifo.sv
// small first-in first-out queue of register entries
// carries event bundles from the front to the back, no package use
module bgd_fifo #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/bgd_front.sv
// front part: configuration registers, debounce and gesture state; uses bgd_pkg
// classifies one sample per cycle while the queue has room into up to three events
module bgd_front #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bgd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bgd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_raw_level,
   input  logic [31:0]                           req_now_ms,
   input  logic                                  queue_full,
   output logic                                  bundle_push,
   output bgd_pkg::bgd_bundle_type               bundle
);

   import bgd_pkg::*;

   localparam int unsigned NCAND = 7;

   bgd_cfg_type cfg_ff, cfg_in;

   logic                 stable_ff, stable_in;
   logic                 last_raw_ff, last_raw_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic [TIME_BITS-1:0] click_time_ff, click_time_in;
   logic [TIME_BITS-1:0] repeat_time_ff, repeat_time_in;
   logic                 long_sent_ff, long_sent_in;
   logic                 pending_ff, pending_in;

   logic [TIME_BITS+31:0] now_wide;
   logic [TIME_BITS+31:0] stamp_wide;
   logic [TIME_BITS-1:0]  now_t;
   logic                  accept;
   logic                  raw_changed, debounced, flip, fall, rise;
   logic [TIME_BITS-1:0]  press_el, click_el, arm_el;
   logic                  in_window, dc_on, follow_up, dbl, arm, click_now, delayed;
   logic                  long_fire, repeat_fire, held, long_sent_e, pending_e;
   logic [TIME_BITS-1:0]  press_e, repeat_e, click_e;
   logic [NCAND-1:0]      cand_en;
   event_kind_type        cand_kind [NCAND];
   event_kind_type [MAX_EVENTS-1:0] kinds;
   logic [1:0]            cnt;

   assign now_wide   = {{TIME_BITS{1'b0}}, req_now_ms};
   assign now_t      = now_wide[TIME_BITS-1:0];
   assign stamp_wide = {32'd0, now_t};
   assign accept     = req_push && !queue_full;
   assign req_full   = queue_full;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE:        cfg_in.debounce_ms        = csr_wdata;
            REG_LONG_PRESS:      cfg_in.long_press_ms      = csr_wdata;
            REG_DOUBLE_CLICK:    cfg_in.double_click_ms    = csr_wdata;
            REG_REPEAT_ENABLE:   cfg_in.repeat_enable      = csr_wdata[0];
            REG_REPEAT_DELAY:    cfg_in.repeat_delay_ms    = csr_wdata;
            REG_REPEAT_INTERVAL: cfg_in.repeat_interval_ms = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // debounce and gesture decisions
   always_comb begin
      raw_changed    = (req_raw_level != last_raw_ff);
      last_raw_in    = req_raw_level;
      change_time_in = raw_changed ? now_t : change_time_ff;
      debounced      = ((now_t - change_time_in) >= TIME_BITS'(cfg_ff.debounce_ms));
      flip           = debounced && (req_raw_level != stable_ff);
      fall           = flip && !req_raw_level;
      rise           = flip && req_raw_level;
      stable_in      = flip ? req_raw_level : stable_ff;

      press_e     = fall ? now_t : press_time_ff;
      repeat_e    = fall ? now_t : repeat_time_ff;
      long_sent_e = fall ? 1'b0 : long_sent_ff;

      dc_on     = (cfg_ff.double_click_ms != '0);
      click_el  = now_t - click_time_ff;
      in_window = (click_el <= TIME_BITS'(cfg_ff.double_click_ms));
      follow_up = rise && !long_sent_ff;
      dbl       = follow_up && dc_on && pending_ff && in_window;
      arm       = follow_up && dc_on && !(pending_ff && in_window);
      click_now = follow_up && !dc_on;
      pending_e = dbl ? 1'b0 : (arm ? 1'b1 : pending_ff);
      click_e   = arm ? now_t : click_time_ff;
      arm_el    = now_t - click_e;
      delayed   = dc_on && pending_e && (arm_el > TIME_BITS'(cfg_ff.double_click_ms));
      pending_in    = delayed ? 1'b0 : pending_e;
      click_time_in = click_e;

      held        = !stable_in;
      press_el    = now_t - press_e;
      long_fire   = held && (cfg_ff.long_press_ms != '0) && !long_sent_e
                    && (press_el >= TIME_BITS'(cfg_ff.long_press_ms));
      repeat_fire = held && cfg_ff.repeat_enable
                    && (press_el >= TIME_BITS'(cfg_ff.repeat_delay_ms))
                    && ((now_t - repeat_e) >= TIME_BITS'(cfg_ff.repeat_interval_ms));

      long_sent_in   = long_fire ? 1'b1 : long_sent_e;
      press_time_in  = press_e;
      repeat_time_in = repeat_fire ? now_t : repeat_e;
   end

   // pack the events in order, at most three kept
   always_comb begin
      cand_en      = {repeat_fire, long_fire, delayed, click_now, dbl, rise, fall};
      cand_kind[0] = EV_PRESS;
      cand_kind[1] = EV_RELEASE;
      cand_kind[2] = EV_DOUBLE;
      cand_kind[3] = EV_CLICK;
      cand_kind[4] = EV_CLICK;
      cand_kind[5] = EV_LONG;
      cand_kind[6] = EV_REPEAT;
      kinds        = '{default: EV_PRESS};
      cnt          = 2'd0;
      for (int i = 0; i < NCAND; i++) begin
         if (cand_en[i] && cnt != 2'(MAX_EVENTS)) begin
            kinds[cnt] = cand_kind[i];
            cnt        = cnt + 2'd1;
         end
      end
      bundle.kinds = kinds;
      bundle.count = cnt;
      bundle.stamp = stamp_wide[31:0];
      bundle_push  = accept && (cnt != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms      <= LONG_PRESS_RESET;
         cfg_ff.double_click_ms    <= DOUBLE_CLICK_RESET;
         cfg_ff.repeat_enable      <= REPEAT_ENABLE_RESET;
         cfg_ff.repeat_delay_ms    <= REPEAT_DELAY_RESET;
         cfg_ff.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
         stable_ff      <= 1'b1;
         last_raw_ff    <= 1'b1;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         click_time_ff  <= '0;
         repeat_time_ff <= '0;
         long_sent_ff   <= 1'b0;
         pending_ff     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            stable_ff      <= stable_in;
            last_raw_ff    <= last_raw_in;
            change_time_ff <= change_time_in;
            press_time_ff  <= press_time_in;
            click_time_ff  <= click_time_in;
            repeat_time_ff <= repeat_time_in;
            long_sent_ff   <= long_sent_in;
            pending_ff     <= pending_in;
         end
      end
   end

endmodule

FILE: rtl/bgd_back.sv
// back part: unpacks event bundles into single events
// one event per cycle into the output register while it is empty or popped; uses bgd_pkg
module bgd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   input  bgd_pkg::bgd_bundle_type head,
   output logic                    queue_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [2:0]              rsp_event_kind,
   output logic [31:0]             rsp_event_time,
   output logic                    rsp_last_event
);

   import bgd_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  kind_ff;
   logic [31:0] time_ff;
   logic        last_ff;
   logic        load, take, is_last;

   always_comb begin
      load      = !valid_ff || rsp_pop;
      take      = load && !queue_empty;
      is_last   = (idx_ff == (head.count - 2'd1));
      queue_pop = take && is_last;
      valid_in  = take || (valid_ff && !rsp_pop);
      idx_in    = idx_ff;
      if (take) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= head.kinds[idx_ff];
         time_ff <= head.stamp;
         last_ff <= is_last;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_event_time = time_ff;
   assign rsp_last_event = last_ff;

endmodule

FILE: rtl/button_gesture_detector_unit.sv
// top level of the button gesture detector
// joins bgd_front, bgd_fifo and bgd_back; uses bgd_pkg
//
// Debounces an active-low button sampled with a millisecond timestamp and
// reports press, release, click, double click, long press and repeat events.
// A sample is taken in every cycle with req_push high and req_full low;
// the front part classifies it in that cycle and, when it causes events,
// places them as one bundle in a queue of QUEUE_DEPTH bundles. The back
// part hands out one event per cycle through an output register while it
// is empty or popped, so the events of a sample (at most three) hold the
// result port until all are popped; the sustained rate is one sample per
// cycle when each causes at most one event and rsp_pop is high. The last
// event of a sample carries rsp_last_event; time wraps at TIME_BITS bits.
module button_gesture_detector_unit #(
   parameter int unsigned TIME_BITS   = 32,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bgd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_raw_level,
   input  logic [31:0]                        req_now_ms,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [2:0]                         rsp_event_kind,
   output logic [31:0]                        rsp_event_time,
   output logic                               rsp_last_event
);

   import bgd_pkg::*;

   localparam int unsigned BUNDLE_BITS = $bits(bgd_bundle_type);

   bgd_bundle_type         push_bundle, head_bundle;
   logic [BUNDLE_BITS-1:0] head_bits;
   logic                   mid_push, mid_full, mid_pop, mid_empty;

   bgd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_raw_level (req_raw_level),
      .req_now_ms    (req_now_ms),
      .queue_full    (mid_full),
      .bundle_push   (mid_push),
      .bundle        (push_bundle)
   );

   bgd_fifo #(
      .WIDTH (BUNDLE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (push_bundle),
      .full      (mid_full),
      .pop       (mid_pop),
      .head_data (head_bits),
      .empty     (mid_empty)
   );

   assign head_bundle = bgd_bundle_type'(head_bits);

   bgd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (mid_empty),
      .head           (head_bundle),
      .queue_pop      (mid_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_time (rsp_event_time),
      .rsp_last_event (rsp_last_event)
   );

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("bundle pushed into a full queue");

   a_push_on_transfer: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (req_push && !req_full))
      else $error("bundle pushed without an input transfer");

   a_pop_gives_last: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> (!rsp_empty && rsp_last_event))
      else $error("bundle retired without its last event");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result port not empty after reset");
`endif

endmodule
